>>> src/hrlp_pkg.sv
// Package for the HTTP request line parser: phase and method codes, character
// constants, the verb table and the result word layout.
// No dependencies.
package hrlp_pkg;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_LEAD   = 4'd1,
        PH_METH   = 4'd2,
        PH_GAP1   = 4'd3,
        PH_URI    = 4'd4,
        PH_GAP2   = 4'd5,
        PH_VPRE0  = 4'd6,
        PH_VPRE   = 4'd7,
        PH_VSLASH = 4'd8,
        PH_MAJOR  = 4'd9,
        PH_MINOR  = 4'd10,
        PH_VREST  = 4'd11,
        PH_DONE   = 4'd12
    } t_phase;

    typedef enum logic [3:0] {
        M_GET     = 4'd0,
        M_POST    = 4'd1,
        M_PUT     = 4'd2,
        M_HEAD    = 4'd3,
        M_PATCH   = 4'd4,
        M_DELETE  = 4'd5,
        M_CONNECT = 4'd6,
        M_OPTIONS = 4'd7,
        M_TRACE   = 4'd8,
        M_UNKNOWN = 4'd9
    } t_method;

    typedef enum logic {
        KIND_URI     = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    localparam int NUM_VERBS = 9;
    localparam int VERB_MAX  = 7;
    localparam int VLEN_W    = 3;

    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [6:0] VER_MAX = 7'd99;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] uri;
        t_method    code;
        logic [6:0] major;
        logic [6:0] minor;
        logic       valid;
        logic       last;
    } t_result;

    // Verb text with the first character in the lowest byte.
    function automatic logic [VERB_MAX*8-1:0] verb_text(input t_method m);
        logic [VERB_MAX*8-1:0] t;
        unique case (m)
            M_GET:     t = (VERB_MAX*8)'("TEG");
            M_POST:    t = (VERB_MAX*8)'("TSOP");
            M_PUT:     t = (VERB_MAX*8)'("TUP");
            M_HEAD:    t = (VERB_MAX*8)'("DAEH");
            M_PATCH:   t = (VERB_MAX*8)'("HCTAP");
            M_DELETE:  t = (VERB_MAX*8)'("ETELED");
            M_CONNECT: t = (VERB_MAX*8)'("TCENNOC");
            M_OPTIONS: t = (VERB_MAX*8)'("SNOITPO");
            M_TRACE:   t = (VERB_MAX*8)'("ECART");
            default:   t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [VLEN_W-1:0] verb_len(input t_method m);
        logic [VLEN_W-1:0] l;
        unique case (m)
            M_GET, M_PUT:                  l = 3'd3;
            M_POST, M_HEAD:                l = 3'd4;
            M_PATCH, M_TRACE:              l = 3'd5;
            M_DELETE:                      l = 3'd6;
            M_CONNECT, M_OPTIONS:          l = 3'd7;
            default:                       l = 3'd0;
        endcase
        return l;
    endfunction

    // Decimal accumulate with saturation at 99.
    function automatic logic [6:0] add_digit(input logic [6:0] acc, input logic [7:0] c);
        logic [10:0] v;
        logic [3:0]  d;
        d = c[3:0];
        v = {acc, 3'b000} + {3'b000, acc, 1'b0} + {7'd0, d};
        return (v > 11'(VER_MAX)) ? VER_MAX : v[6:0];
    endfunction

endpackage

>>> src/http_request_line_parser.sv
// HTTP request line parser top level: byte parser and a three-word result queue.
// Depends on hrlp_pkg.
//
//  channel | dir | tdata                              | tuser     | tlast
//  s_axis  | in  | byte_in[7:0]                       | -         | last_byte
//  m_axis  | out | uri_byte, method_code, major, ...  | item_kind | last_result
//
// Each byte is parsed in the cycle in which it is taken; its up to two
// words go into a three-entry queue whose head drives the output.
// s_axis_tready is high while the queue holds at most one word, so a steady
// stream of one word per byte runs at one byte per clock while m_axis_tready is high.
// Reset clears the parser state and empties the queue.
module http_request_line_parser
    import hrlp_pkg::*;
#(
    parameter int METHOD_CHARS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] uri_byte, [11:8] method_code,
                                        // [18:12] version_major,
                                        // [25:19] version_minor,
                                        // [26] version_valid, [31:27] zero
    output logic        m_axis_tuser,   // [0] item_kind
    output logic        m_axis_tlast
);

    localparam int LEN_W = $clog2(METHOD_CHARS + 1);
    localparam int QD    = 3;

    t_phase              r_phase, n_phase;
    logic [7:0]          r_chars [METHOD_CHARS];
    logic [7:0]          n_chars [METHOD_CHARS];
    logic [LEN_W-1:0]    r_len, n_len;
    logic                r_long, n_long;
    logic [6:0]          r_major, n_major;
    logic [6:0]          r_minor, n_minor;
    logic                r_seen, n_seen;

    t_result             r_q [QD];
    t_result             n_q [QD];
    logic [1:0]          r_count, n_count;

    logic [7:0]          c;
    logic                take;
    logic                is_dig;
    logic                line_end;
    logic                uri_out;
    logic                sum_out;
    logic                append;
    t_method             code;
    t_result             res_uri, res_sum, res0, res1;
    logic                push0, push1;
    logic                pop;
    logic [1:0]          base;

    assign c      = s_axis_tdata;
    assign take   = s_axis_tvalid && s_axis_tready;
    assign is_dig = (c >= CH_ZERO) && (c <= CH_NINE);

    always_comb begin
        n_phase  = r_phase;
        n_major  = r_major;
        n_minor  = r_minor;
        n_seen   = r_seen;
        n_long   = r_long;
        n_len    = r_len;
        append   = 1'b0;
        line_end = 1'b0;
        uri_out  = 1'b0;
        if (r_phase != PH_DONE) begin
            if (c == CH_NL) begin
                line_end = (r_phase != PH_IDLE);
            end else begin
                unique case (r_phase)
                    PH_IDLE, PH_LEAD, PH_METH: begin
                        if (c == CH_SPACE) begin
                            n_phase = (r_phase == PH_METH) ? PH_GAP1 : PH_LEAD;
                        end else begin
                            n_phase = PH_METH;
                            if (r_len < LEN_W'(METHOD_CHARS)) begin
                                append = 1'b1;
                                n_len  = r_len + 1'b1;
                            end else begin
                                n_long = 1'b1;
                            end
                        end
                    end
                    PH_GAP1, PH_URI: begin
                        if (c == CH_SPACE) begin
                            if (r_phase == PH_URI) begin
                                n_phase = PH_GAP2;
                            end
                        end else begin
                            n_phase = PH_URI;
                            uri_out = 1'b1;
                        end
                    end
                    PH_GAP2: begin
                        if (c != CH_SPACE) begin
                            n_phase = (c == CH_SLASH) ? PH_VPRE0 : PH_VPRE;
                        end
                    end
                    PH_VPRE0: begin
                        if (c == CH_SPACE) begin
                            n_phase = PH_VREST;
                        end else if (c != CH_SLASH) begin
                            n_phase = PH_VPRE;
                        end
                    end
                    PH_VPRE: begin
                        if (c == CH_SPACE) begin
                            n_phase = PH_VREST;
                        end else if (c == CH_SLASH) begin
                            n_phase = PH_VSLASH;
                        end
                    end
                    PH_VSLASH, PH_MAJOR: begin
                        if (is_dig) begin
                            n_major = add_digit(r_major, c);
                            n_seen  = 1'b1;
                            n_phase = PH_MAJOR;
                        end else if (c == CH_DOT) begin
                            n_phase = PH_MINOR;
                        end else if (!(c == CH_SLASH && r_phase == PH_VSLASH)) begin
                            n_phase = PH_VREST;
                        end
                    end
                    PH_MINOR: begin
                        if (is_dig) begin
                            n_minor = add_digit(r_minor, c);
                            n_seen  = 1'b1;
                        end else begin
                            n_phase = PH_VREST;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        sum_out = (r_phase != PH_DONE) && (line_end || s_axis_tlast);
        if (sum_out) begin
            n_phase = PH_DONE;
        end
    end

    always_comb begin
        for (int j = 0; j < METHOD_CHARS; j++) begin
            n_chars[j] = (append && r_len == LEN_W'(j)) ? c : r_chars[j];
        end
    end

    // Method match on the updated token; the lowest code wins.
    always_comb begin
        logic [VERB_MAX*8-1:0] txt;
        logic                  hit;
        code = M_UNKNOWN;
        for (int i = NUM_VERBS - 1; i >= 0; i--) begin
            txt = verb_text(t_method'(i));
            hit = (n_len == LEN_W'(verb_len(t_method'(i))));
            for (int p = 0; p < VERB_MAX; p++) begin
                if (p < int'(verb_len(t_method'(i))) && n_chars[p] != txt[p*8 +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                code = t_method'(i);
            end
        end
        if (n_long || n_len == '0) begin
            code = M_UNKNOWN;
        end
    end

    always_comb begin
        res_uri       = '0;
        res_uri.kind  = KIND_URI;
        res_uri.uri   = c;
        res_uri.code  = M_GET;
        res_uri.last  = !sum_out;
        res_sum       = '0;
        res_sum.kind  = KIND_SUMMARY;
        res_sum.code  = code;
        res_sum.major = n_major;
        res_sum.minor = n_minor;
        res_sum.valid = n_seen;
        res_sum.last  = 1'b1;
        res0  = uri_out ? res_uri : res_sum;
        res1  = res_sum;
        push0 = take && (uri_out || sum_out);
        push1 = take && uri_out && sum_out;
    end

    assign pop  = (r_count != 2'd0) && m_axis_tready;
    assign base = r_count - {1'b0, pop};

    always_comb begin
        for (int k = 0; k < QD; k++) begin
            if (pop && k < QD - 1) begin
                n_q[k] = r_q[(k + 1) % QD];
            end else begin
                n_q[k] = r_q[k];
            end
            if (push0 && base == 2'(k)) begin
                n_q[k] = res0;
            end
            if (push1 && (base + 2'd1) == 2'(k)) begin
                n_q[k] = res1;
            end
        end
        n_count = base + {1'b0, push0} + {1'b0, push1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_len   <= '0;
            r_long  <= 1'b0;
            r_major <= '0;
            r_minor <= '0;
            r_seen  <= 1'b0;
            r_count <= '0;
            for (int j = 0; j < METHOD_CHARS; j++) begin
                r_chars[j] <= '0;
            end
        end else begin
            r_count <= n_count;
            if (take) begin
                if (s_axis_tlast) begin
                    r_phase <= PH_IDLE;
                    r_len   <= '0;
                    r_long  <= 1'b0;
                    r_major <= '0;
                    r_minor <= '0;
                    r_seen  <= 1'b0;
                    for (int j = 0; j < METHOD_CHARS; j++) begin
                        r_chars[j] <= '0;
                    end
                end else begin
                    r_phase <= n_phase;
                    r_len   <= n_len;
                    r_long  <= n_long;
                    r_major <= n_major;
                    r_minor <= n_minor;
                    r_seen  <= n_seen;
                    r_chars <= n_chars;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign s_axis_tready = (r_count <= 2'd1);
    assign m_axis_tvalid = (r_count != 2'd0);
    assign m_axis_tdata  = {5'd0, r_q[0].valid, r_q[0].minor, r_q[0].major,
                            r_q[0].code, r_q[0].uri};
    assign m_axis_tuser  = r_q[0].kind;
    assign m_axis_tlast  = r_q[0].last;

endmodule
